// ===== rtl/core/ucfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ucfp_pkg
// Shared types and constants for the command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] COMMAND_RESET = 8'h01;
  localparam logic [BYTE_W-1:0] LENGTH_CODE   = 8'h03;

  localparam logic [POS_W-1:0] POS_IDLE    = 3'd0;
  localparam logic [POS_W-1:0] POS_LENGTH  = 3'd1;
  localparam logic [POS_W-1:0] POS_COMMAND = 3'd2;
  localparam logic [POS_W-1:0] POS_FIRST   = 3'd3;
  localparam logic [POS_W-1:0] POS_SECOND  = 3'd4;
  localparam logic [POS_W-1:0] POS_CHECK   = 3'd5;
  localparam logic [POS_W-1:0] POS_DONE    = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] command_value;
  } cfg_t;

  typedef struct packed {
    logic              frame_status;
    logic [BYTE_W-1:0] payload_first;
    logic [BYTE_W-1:0] payload_second;
  } result_t;

  // running check: add, and on carry replace by negation mod 256
  function automatic logic [BYTE_W-1:0] check_add(input logic [BYTE_W-1:0] sum,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, sum} + {1'b0, b};
    if (s[BYTE_W]) begin
      return (~s[BYTE_W-1:0]) + 8'd1;
    end
    return s[BYTE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ucfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ucfp_cfg_regs
// Configuration register file: header and command byte values.
// ----------------------------------------------------------------------------
module ucfp_cfg_regs import ucfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value  <= HEADER_RESET;
      cfg.command_value <= COMMAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER:  cfg.header_value  <= cfg_data;
        REG_COMMAND: cfg.command_value <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ucfp_frame_track.sv =====
// ----------------------------------------------------------------------------
// ucfp_frame_track
// Frame position and running check; flags a result on the check byte.
// ----------------------------------------------------------------------------
module ucfp_frame_track import ucfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output logic              res_valid,
  output result_t           res,
  output logic              in_frame,
  output logic [POS_W-1:0]  byte_position
);

  logic              in_frame_next;
  logic [POS_W-1:0]  byte_position_next;
  logic [BYTE_W-1:0] running_check, running_check_next;
  logic [BYTE_W-1:0] held_first, held_first_next;
  logic [BYTE_W-1:0] held_second, held_second_next;
  logic              hit;

  always_comb begin
    in_frame_next      = in_frame;
    byte_position_next = byte_position;
    running_check_next = running_check;
    held_first_next    = held_first;
    held_second_next   = held_second;
    hit                = 1'b0;
    if (rx_byte == cfg.header_value) begin
      in_frame_next      = 1'b1;
      byte_position_next = POS_LENGTH;
      running_check_next = '0;
    end else if (in_frame) begin
      byte_position_next = byte_position + 3'd1;
      unique case (byte_position)
        POS_LENGTH: begin
          if (rx_byte != LENGTH_CODE) begin
            in_frame_next      = 1'b0;
            byte_position_next = byte_position;
          end else begin
            running_check_next = check_add(running_check, rx_byte);
          end
        end
        POS_COMMAND: begin
          if (rx_byte != cfg.command_value) begin
            in_frame_next      = 1'b0;
            byte_position_next = byte_position;
          end else begin
            running_check_next = check_add(running_check, rx_byte);
          end
        end
        POS_FIRST: begin
          held_first_next    = rx_byte;
          running_check_next = check_add(running_check, rx_byte);
        end
        POS_SECOND: begin
          held_second_next   = rx_byte;
          running_check_next = check_add(running_check, rx_byte);
        end
        POS_CHECK: begin
          in_frame_next      = 1'b0;
          byte_position_next = POS_DONE;
          hit                = 1'b1;
        end
        default: begin
          in_frame_next      = 1'b0;
          byte_position_next = byte_position;
        end
      endcase
    end
  end

  assign res_valid          = take && hit;
  assign res.frame_status   = (rx_byte != running_check);
  assign res.payload_first  = held_first;
  assign res.payload_second = held_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= POS_IDLE;
      running_check <= '0;
      held_first    <= '0;
      held_second   <= '0;
    end else if (take) begin
      in_frame      <= in_frame_next;
      byte_position <= byte_position_next;
      running_check <= running_check_next;
      held_first    <= held_first_next;
      held_second   <= held_second_next;
    end
  end

endmodule

// ===== rtl/core/ucfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// ucfp_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module ucfp_out_buf import ucfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
          if (push) begin
            out_data <= push_data;
          end
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule

// ===== rtl/core/uart_command_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// uart_command_frame_parser_unit
// Finds six-byte host command frames in a received byte stream.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / rx_byte) takes one byte per
//   transaction. each taken byte updates the registered frame position and
//   running check, so a byte can be taken every cycle while in_stall is low.
//   output channel (out_valid / out_stall / frame_status, payload_first,
//   payload_second) gives one transaction per complete frame, registered
//   once the check byte is taken. frame_status is 0 on a matching check byte.
//   a result register plus one skid entry sit on the output; bytes keep
//   flowing while one result waits. in_stall rises only once both hold a
//   result, and drops the cycle after the receiver takes one.
//   configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; index 0 is the header byte, index 1 the command byte. write it
//   only while the block is idle.
//   reset clears frame tracking and output valids, and restores header 0xAA
//   and command 0x01.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_unit import ucfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 frame_status,
  output logic [BYTE_W-1:0]    payload_first,
  output logic [BYTE_W-1:0]    payload_second
);

  cfg_t             cfg;
  logic             take;
  logic             res_valid;
  result_t          res;
  result_t          out_data;
  logic             buf_full;
  logic             in_frame;
  logic [POS_W-1:0] byte_position;

  assign in_stall = buf_full;
  assign take     = in_valid && !in_stall;

  ucfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ucfp_frame_track u_track (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .rx_byte       (rx_byte),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res),
    .in_frame      (in_frame),
    .byte_position (byte_position)
  );

  ucfp_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign frame_status   = out_data.frame_status;
  assign payload_first  = out_data.payload_first;
  assign payload_second = out_data.payload_second;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> (byte_position != POS_IDLE && byte_position <= POS_CHECK))
    else $error("frame position out of range");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> !res_valid)
    else $error("result produced while output buffer full");

  a_result_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !in_frame)
    else $error("still in frame after check byte");

endmodule
